FILE: rtl/sm4_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SM4 package
// Shared state codes, register indexes, and the fixed cipher constants
// (FK, CK, S-box).
// ---------------------------------------------------------------------------
package sm4_pkg;

   localparam int ROUNDS = 32;
   localparam int RND_W  = $clog2(ROUNDS);

   // Configuration register indexes.
   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [1:0] CSR_MODE     = 2'd2;

   localparam logic [31:0] FK0 = 32'ha3b1bac6;
   localparam logic [31:0] FK1 = 32'h56aa3350;
   localparam logic [31:0] FK2 = 32'h677d9197;
   localparam logic [31:0] FK3 = 32'hb27022dc;

   typedef enum logic [2:0] {
      ST_KEYLOAD,
      ST_EXPAND,
      ST_IDLE,
      ST_ROUND,
      ST_FLUSH
   } state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
      8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
      8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
      8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
      8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
      8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
      8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
      8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
      8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
      8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
      8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
      8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
      8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
      8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
      8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
      8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
      8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
      8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
      8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
      8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
      8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
      8'hD7, 8'hCB, 8'h39, 8'h48
   };

   // CK word for key-schedule round i: byte j is (4*i + j) * 7 mod 256.
   function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
      logic [31:0] w;
      logic [7:0]  base;
      logic [7:0]  b;
      w    = '0;
      base = {1'b0, i, 2'b00};
      for (int j = 0; j < 4; j++) begin
         b = (base + 8'(j)) * 8'd7;
         w = {w[23:0], b};
      end
      return w;
   endfunction

endpackage

FILE: rtl/sm4_round.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SM4 round function
// One round of the shared datapath: S-box layer on X1^X2^X3^RK, then the
// cipher linear transform L or the key-schedule transform L'.
// ---------------------------------------------------------------------------
module sm4_round
   import sm4_pkg::*;
(
   input  logic [31:0] w0,
   input  logic [31:0] w1,
   input  logic [31:0] w2,
   input  logic [31:0] w3,
   input  logic [31:0] rk,
   input  logic        key_sched,
   output logic [31:0] nx
);

   function automatic logic [31:0] tau(input logic [31:0] v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   logic [31:0] t;
   logic [31:0] lin_cipher;
   logic [31:0] lin_key;

   always_comb begin
      t          = tau(w1 ^ w2 ^ w3 ^ rk);
      lin_cipher = t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
      lin_key    = t ^ rotl(t, 13) ^ rotl(t, 23);
      nx         = w0 ^ (key_sched ? lin_key : lin_cipher);
   end

endmodule

FILE: rtl/sm4_block_cipher_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SM4 block cipher top level
// Round keys live in a 32-entry synchronous memory filled by the key
// schedule; one shared round unit runs both the schedule and the cipher.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake          Payload
//  req_*     in         tvalid / tready    tdata: block_high, block_low
//  rsp_*     out        tvalid / tready    tdata: result_high, result_low
//  csr_*     in         write enable only  index, wdata (64 bits)
//
// Each item takes an accept step, 32 rounds at one round and one round-key
// memory read per cycle, and a step that loads the output register, and the
// next item is accepted only after that. The result register lets a new item
// start while a result waits. After reset and after any key write the key
// schedule runs (a load, 32 rounds) before the next item is accepted. A stalled
// result holds the block in its final cycle until the output register frees.
// ---------------------------------------------------------------------------
module sm4_block_cipher_top
   import sm4_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] block_high, [127:64] block_low
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // [63:0] result_high, [127:64] result_low
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [63:0]      key_high_ff;
   logic [63:0]      key_low_ff;
   logic             mode_ff;
   logic [RND_W-1:0] cnt_ff;
   logic [31:0]      w0_ff, w1_ff, w2_ff, w3_ff;
   logic [31:0]      rk_rd_ff;
   logic [31:0]      rk_mem_ff [ROUNDS];
   logic             rsp_valid_ff;
   logic [127:0]     rsp_data_ff;

   logic             key_write;
   logic             accept;
   logic             last_round;
   logic             out_free;
   logic             do_keyload;
   logic             do_expand;
   logic             do_round;
   logic             do_out;
   logic [RND_W-1:0] rd_round;
   logic [RND_W-1:0] rd_addr;
   logic [31:0]      round_rk;
   logic [31:0]      nx;

   assign key_write  = csr_we && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW);
   assign accept     = req_tvalid && req_tready;
   assign last_round = (cnt_ff == RND_W'(ROUNDS - 1));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_KEYLOAD: state_in = ST_EXPAND;
         ST_EXPAND:  if (last_round) begin
            state_in = ST_IDLE;
         end
         ST_IDLE:    if (req_tvalid) begin
            state_in = ST_ROUND;
         end
         ST_ROUND:   if (last_round) begin
            state_in = ST_FLUSH;
         end
         ST_FLUSH:   if (out_free) begin
            state_in = ST_IDLE;
         end
         default:    state_in = ST_KEYLOAD;
      endcase
      // A new key restarts the schedule from the top.
      if (key_write) begin
         state_in = ST_KEYLOAD;
      end
   end

   // Control outputs.
   always_comb begin
      req_tready = 1'b0;
      do_keyload = 1'b0;
      do_expand  = 1'b0;
      do_round   = 1'b0;
      do_out     = 1'b0;
      unique case (state_ff)
         ST_KEYLOAD: do_keyload = 1'b1;
         ST_EXPAND:  do_expand  = 1'b1;
         ST_IDLE:    req_tready = 1'b1;
         ST_ROUND:   do_round   = 1'b1;
         ST_FLUSH:   do_out     = out_free;
         default:    do_keyload = 1'b0;
      endcase
   end

   // Round key for the next round; decryption walks the memory backward.
   assign rd_round = accept ? '0 : cnt_ff + RND_W'(1);
   assign rd_addr  = mode_ff ? rd_round : RND_W'(ROUNDS - 1) - rd_round;
   assign round_rk = do_expand ? ck_word(cnt_ff) : rk_rd_ff;

   sm4_round u_round (
      .w0        (w0_ff),
      .w1        (w1_ff),
      .w2        (w2_ff),
      .w3        (w3_ff),
      .rk        (round_rk),
      .key_sched (do_expand),
      .nx        (nx)
   );

   always_ff @(posedge clock) begin
      if (do_expand) begin
         rk_mem_ff[cnt_ff] <= nx;
      end
      rk_rd_ff <= rk_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KEYLOAD;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         mode_ff      <= 1'b1;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_HIGH: key_high_ff <= csr_wdata;
               CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
               CSR_MODE:     mode_ff     <= csr_wdata[0];
               default:      mode_ff     <= mode_ff;
            endcase
         end
         if (do_keyload || accept) begin
            cnt_ff <= '0;
         end else if (do_expand || do_round) begin
            cnt_ff <= cnt_ff + RND_W'(1);
         end
         if (do_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_keyload) begin
         w0_ff <= key_high_ff[63:32] ^ FK0;
         w1_ff <= key_high_ff[31:0]  ^ FK1;
         w2_ff <= key_low_ff[63:32]  ^ FK2;
         w3_ff <= key_low_ff[31:0]   ^ FK3;
      end else if (accept) begin
         w0_ff <= req_tdata[63:32];
         w1_ff <= req_tdata[31:0];
         w2_ff <= req_tdata[127:96];
         w3_ff <= req_tdata[95:64];
      end else if (do_expand || do_round) begin
         w0_ff <= w1_ff;
         w1_ff <= w2_ff;
         w2_ff <= w3_ff;
         w3_ff <= nx;
      end
      if (do_out) begin
         rsp_data_ff <= {w1_ff, w0_ff, w3_ff, w2_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_starts_rounds : assert property (@(posedge clock) disable iff (reset)
      accept && !key_write |=> state_ff == ST_ROUND && cnt_ff == '0)
      else $error("accepted item did not start the round sequence");

   a_key_write_restarts : assert property (@(posedge clock) disable iff (reset)
      key_write |=> state_ff == ST_KEYLOAD)
      else $error("key write did not restart the key schedule");

   a_rounds_end_in_flush : assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROUND && last_round && !key_write |=> state_ff == ST_FLUSH)
      else $error("round sequence did not end after the last round");

   a_result_from_flush : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FLUSH)
      else $error("result appeared outside the final cycle");

endmodule
